[hw/rtl/bst_pkg.sv]
// Shared constants, token kind codes and byte classification helpers for the tokenizer.
package bst_pkg;

  // Configuration port.
  localparam int CFG_WIDTH = 16;
  localparam logic REG_FIRST_LINE   = 1'b0;
  localparam logic REG_FIRST_COLUMN = 1'b1;

  // Most tokens one source item can cause.
  localparam int MAX_RESULTS = 3;

  // Token queue geometry.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Scanner modes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;

  // Token kinds.
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_NEWLINE = 4'd1;
  localparam logic [3:0] K_VAR     = 4'd2;
  localparam logic [3:0] K_IDENT   = 4'd3;
  localparam logic [3:0] K_NUMBER  = 4'd4;
  localparam logic [3:0] K_COMMA   = 4'd5;
  localparam logic [3:0] K_DOT     = 4'd6;
  localparam logic [3:0] K_PLUS    = 4'd7;
  localparam logic [3:0] K_MINUS   = 4'd8;
  localparam logic [3:0] K_STAR    = 4'd9;
  localparam logic [3:0] K_SLASH   = 4'd10;
  localparam logic [3:0] K_EQ      = 4'd11;
  localparam logic [3:0] K_UNKNOWN = 4'd12;

  // Identifier length counter.
  localparam logic [2:0] IDENT_LEN_KW  = 3'd3;
  localparam logic [2:0] IDENT_LEN_MAX = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Letters of the keyword, by position.
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h76;
      2'd1:    c = 8'h61;
      default: c = 8'h72;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/bst_scanner.sv]
// Scanner state, byte classification and up to three tokens per source item.
module bst_scanner #(
  parameter int POSITION_BITS = 16,
  localparam int TOK_W = 4 + 4 * POSITION_BITS + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic [7:0]                         ch,
  input  logic                               ch_present,
  input  logic                               end_of_source,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [bst_pkg::CFG_WIDTH-1:0]      cfg_data,
  output logic [1:0]                         push_count,
  output logic [bst_pkg::MAX_RESULTS-1:0][TOK_W-1:0] push_tokens
);

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [3:0] kind;
    pos_t       start;
    pos_t       stop;
    pos_t       line;
    pos_t       column;
    logic       last;
  } token_t;

  localparam logic [32:0] POS_MAX33 = (33'd1 << POSITION_BITS) - 33'd1;

  function automatic pos_t sat_inc(input pos_t v);
    return (&v) ? v : v + pos_t'(1);
  endfunction

  // Architectural state.
  logic [1:0] mode;
  pos_t       tok_start, tok_line, tok_column;
  pos_t       cur_offset, cur_line, cur_column;
  logic [2:0] ident_length;
  logic       ident_matches_var;
  pos_t       first_line, first_column;

  logic [1:0] mode_next;
  pos_t       tok_start_next, tok_line_next, tok_column_next;
  pos_t       cur_offset_next, cur_line_next, cur_column_next;
  logic [2:0] ident_length_next;
  logic       ident_matches_var_next;

  // Candidate tokens in emission order: flush, byte token, late flush, end.
  token_t     cand [4];
  logic [3:0] cand_valid;
  token_t     slot [bst_pkg::MAX_RESULTS];
  logic [1:0] n_slot;

  logic       cont_num, cont_id, taken, byte_digit, byte_alpha;
  logic       is_skip, is_single;
  logic [3:0] single_kind;
  logic       take_match;
  logic [32:0] cfg_wide;
  pos_t       cfg_value;

  // Clamp a configuration value into the position range.
  assign cfg_wide  = {{(33 - bst_pkg::CFG_WIDTH){1'b0}}, cfg_data};
  assign cfg_value = (cfg_wide > POS_MAX33) ? '1 : cfg_wide[POSITION_BITS-1:0];

  // Byte classification.
  assign byte_digit = bst_pkg::is_digit(ch);
  assign byte_alpha = bst_pkg::is_alpha(ch);
  assign cont_num   = (mode == bst_pkg::MODE_NUMBER) && byte_digit;
  assign cont_id    = (mode == bst_pkg::MODE_IDENT) &&
                      (byte_alpha || (ch == bst_pkg::CH_UNDER));
  assign taken      = cont_num || cont_id;
  assign is_skip    = (ch == bst_pkg::CH_SPACE) || (ch == bst_pkg::CH_TAB) ||
                      (ch == bst_pkg::CH_CR);
  assign is_single  = !is_skip && (ch != bst_pkg::CH_LF) && !byte_digit && !byte_alpha;

  // Keyword match for an identifier byte taken at the current length.
  assign take_match = (ident_length < bst_pkg::IDENT_LEN_KW) &&
                      (ch == bst_pkg::kw_char(ident_length[1:0]));

  // Kind of a one-byte token.
  always_comb begin
    unique case (ch)
      bst_pkg::CH_COMMA: single_kind = bst_pkg::K_COMMA;
      bst_pkg::CH_DOT:   single_kind = bst_pkg::K_DOT;
      bst_pkg::CH_PLUS:  single_kind = bst_pkg::K_PLUS;
      bst_pkg::CH_MINUS: single_kind = bst_pkg::K_MINUS;
      bst_pkg::CH_STAR:  single_kind = bst_pkg::K_STAR;
      bst_pkg::CH_SLASH: single_kind = bst_pkg::K_SLASH;
      bst_pkg::CH_EQ:    single_kind = bst_pkg::K_EQ;
      default:           single_kind = bst_pkg::K_UNKNOWN;
    endcase
  end

  // Next state and candidate tokens for one source item.
  always_comb begin
    mode_next              = mode;
    tok_start_next         = tok_start;
    tok_line_next          = tok_line;
    tok_column_next        = tok_column;
    cur_offset_next        = cur_offset;
    cur_line_next          = cur_line;
    cur_column_next        = cur_column;
    ident_length_next      = ident_length;
    ident_matches_var_next = ident_matches_var;
    cand_valid             = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    // Byte part.
    if (ch_present) begin
      if (taken) begin
        if (cont_id) begin
          ident_matches_var_next = ident_matches_var && take_match;
          if (ident_length < bst_pkg::IDENT_LEN_MAX) begin
            ident_length_next = ident_length + 3'd1;
          end
        end
        cur_offset_next = sat_inc(cur_offset);
        cur_column_next = sat_inc(cur_column);
      end else begin
        // A pending number or identifier ends here.
        if (mode != bst_pkg::MODE_IDLE) begin
          cand_valid[0] = 1'b1;
          if (mode == bst_pkg::MODE_NUMBER) begin
            cand[0].kind = bst_pkg::K_NUMBER;
          end else if (ident_matches_var && (ident_length == bst_pkg::IDENT_LEN_KW)) begin
            cand[0].kind = bst_pkg::K_VAR;
          end else begin
            cand[0].kind = bst_pkg::K_IDENT;
          end
          cand[0].start  = tok_start;
          cand[0].stop   = cur_offset;
          cand[0].line   = tok_line;
          cand[0].column = tok_column;
          mode_next      = bst_pkg::MODE_IDLE;
        end
        cand[1].start  = cur_offset;
        cand[1].stop   = sat_inc(cur_offset);
        cand[1].line   = cur_line;
        cand[1].column = cur_column;
        if (ch == bst_pkg::CH_LF) begin
          cand_valid[1]   = 1'b1;
          cand[1].kind    = bst_pkg::K_NEWLINE;
          cur_offset_next = sat_inc(cur_offset);
          cur_line_next   = sat_inc(cur_line);
          cur_column_next = first_column;
        end else begin
          if (is_single) begin
            cand_valid[1] = 1'b1;
            cand[1].kind  = single_kind;
          end else if (byte_digit || byte_alpha) begin
            tok_start_next  = cur_offset;
            tok_line_next   = cur_line;
            tok_column_next = cur_column;
            if (byte_digit) begin
              mode_next = bst_pkg::MODE_NUMBER;
            end else begin
              mode_next              = bst_pkg::MODE_IDENT;
              ident_length_next      = 3'd1;
              ident_matches_var_next = (ch == bst_pkg::kw_char(2'd0));
            end
          end
          cur_offset_next = sat_inc(cur_offset);
          cur_column_next = sat_inc(cur_column);
        end
      end
    end

    // End of source: flush what is pending, then the end token, then restart.
    if (end_of_source) begin
      if (mode_next != bst_pkg::MODE_IDLE) begin
        cand_valid[2] = 1'b1;
        if (mode_next == bst_pkg::MODE_NUMBER) begin
          cand[2].kind = bst_pkg::K_NUMBER;
        end else if (ident_matches_var_next &&
                     (ident_length_next == bst_pkg::IDENT_LEN_KW)) begin
          cand[2].kind = bst_pkg::K_VAR;
        end else begin
          cand[2].kind = bst_pkg::K_IDENT;
        end
        cand[2].start  = tok_start_next;
        cand[2].stop   = cur_offset_next;
        cand[2].line   = tok_line_next;
        cand[2].column = tok_column_next;
      end
      cand_valid[3]  = 1'b1;
      cand[3].kind   = bst_pkg::K_END;
      cand[3].start  = cur_offset_next;
      cand[3].stop   = cur_offset_next;
      cand[3].line   = cur_line_next;
      cand[3].column = cur_column_next;

      mode_next              = bst_pkg::MODE_IDLE;
      tok_start_next         = '0;
      tok_line_next          = '0;
      tok_column_next        = '0;
      cur_offset_next        = '0;
      cur_line_next          = first_line;
      cur_column_next        = first_column;
      ident_length_next      = '0;
      ident_matches_var_next = 1'b1;
    end
  end

  // Pack the valid candidates into consecutive slots and mark the last one.
  always_comb begin
    n_slot = '0;
    for (int i = 0; i < bst_pkg::MAX_RESULTS; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_valid[i]) begin
        slot[n_slot] = cand[i];
        n_slot       = n_slot + 2'd1;
      end
    end
    if (n_slot != 2'd0) begin
      slot[n_slot - 2'd1].last = 1'b1;
    end
  end

  assign push_count = take ? n_slot : 2'd0;

  always_comb begin
    for (int i = 0; i < bst_pkg::MAX_RESULTS; i++) begin
      push_tokens[i] = slot[i];
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= bst_pkg::MODE_IDLE;
      tok_start         <= '0;
      tok_line          <= '0;
      tok_column        <= '0;
      cur_offset        <= '0;
      cur_line          <= pos_t'(1);
      cur_column        <= '0;
      ident_length      <= '0;
      ident_matches_var <= 1'b1;
      first_line        <= pos_t'(1);
      first_column      <= '0;
    end else begin
      if (take) begin
        mode              <= mode_next;
        tok_start         <= tok_start_next;
        tok_line          <= tok_line_next;
        tok_column        <= tok_column_next;
        cur_offset        <= cur_offset_next;
        cur_line          <= cur_line_next;
        cur_column        <= cur_column_next;
        ident_length      <= ident_length_next;
        ident_matches_var <= ident_matches_var_next;
      end else if (cfg_write && (cur_offset == '0)) begin
        // Before the first byte of a source, a write also reloads the position.
        if (cfg_index == bst_pkg::REG_FIRST_LINE) begin
          cur_line <= cfg_value;
        end else begin
          cur_column <= cfg_value;
        end
      end
      if (cfg_write) begin
        if (cfg_index == bst_pkg::REG_FIRST_LINE) begin
          first_line <= cfg_value;
        end else begin
          first_column <= cfg_value;
        end
      end
    end
  end

endmodule

[hw/rtl/bst_token_queue.sv]
// Small token queue that takes up to three tokens per cycle and hands out one.
module bst_token_queue #(
  parameter int POSITION_BITS = 16,
  localparam int TOK_W = 4 + 4 * POSITION_BITS + 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [1:0]                                 push_count,
  input  logic [bst_pkg::MAX_RESULTS-1:0][TOK_W-1:0] push_tokens,
  input  logic                                       pop,
  output logic                                       head_valid,
  output logic [TOK_W-1:0]                           head_token,
  output logic                                       room
);

  logic [TOK_W-1:0]              entries [bst_pkg::QUEUE_DEPTH];
  logic [bst_pkg::QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [bst_pkg::QUEUE_AW:0]    count;
  logic                          do_pop;

  assign head_valid = (count != '0);
  assign head_token = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Room for a full item's worth of tokens, decided from registered state.
  assign room = (count <= (bst_pkg::QUEUE_AW + 1)'(bst_pkg::QUEUE_DEPTH -
                                                   bst_pkg::MAX_RESULTS));

  // Token storage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < bst_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push_count) begin
        entries[wr_ptr + bst_pkg::QUEUE_AW'(i)] <= push_tokens[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bst_pkg::QUEUE_AW'(push_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + bst_pkg::QUEUE_AW'(1);
      end
      count <= count + (bst_pkg::QUEUE_AW + 1)'(push_count) -
               (bst_pkg::QUEUE_AW + 1)'(do_pop);
    end
  end

endmodule

[hw/rtl/byte_stream_tokenizer_top.sv]
// Top level of the byte stream tokenizer: scanner feeding a token queue.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   ch, ch_present, end_of_source
//   out      output     out_valid/out_stall tok_kind, start_offset, end_offset,
//                                           line_number, column_number, run_last
//   cfg      input      cfg_write           cfg_index, cfg_data
//
// An item is scanned in the cycle of its transfer and its tokens (up to three) are
// written to a four-entry queue; tokens leave it one per cycle while out_stall is low.
// The input is taken whenever the queue holds at most one token, so items that cause
// at most one token each flow at one per cycle while out_stall is low.
// Synchronous reset returns the scanner to the start of a source with first_line = 1
// and first_column = 0, and empties the queue. out_stall holds the head token in place.
module byte_stream_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    ch,
  input  logic                          ch_present,
  input  logic                          end_of_source,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    tok_kind,
  output logic [POSITION_BITS-1:0]      start_offset,
  output logic [POSITION_BITS-1:0]      end_offset,
  output logic [POSITION_BITS-1:0]      line_number,
  output logic [POSITION_BITS-1:0]      column_number,
  output logic                          run_last,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [bst_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int TOK_W = 4 + 4 * POSITION_BITS + 1;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [3:0] kind;
    pos_t       start;
    pos_t       stop;
    pos_t       line;
    pos_t       column;
    logic       last;
  } token_t;

  logic                                       take;
  logic                                       room;
  logic [1:0]                                 push_count;
  logic [bst_pkg::MAX_RESULTS-1:0][TOK_W-1:0] push_tokens;
  logic [TOK_W-1:0]                           head_bits;
  token_t                                     head;

  // Input transfer.
  assign in_stall = !room;
  assign take     = in_valid && room;

  bst_scanner #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scanner (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .ch            (ch),
    .ch_present    (ch_present),
    .end_of_source (end_of_source),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push_count    (push_count),
    .push_tokens   (push_tokens)
  );

  bst_token_queue #(
    .POSITION_BITS (POSITION_BITS)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_tokens (push_tokens),
    .pop         (!out_stall),
    .head_valid  (out_valid),
    .head_token  (head_bits),
    .room        (room)
  );

  // Output payload from the queue head.
  assign head          = head_bits;
  assign tok_kind      = head.kind;
  assign start_offset  = head.start;
  assign end_offset    = head.stop;
  assign line_number   = head.line;
  assign column_number = head.column;
  assign run_last      = head.last;

endmodule

[tb/tb_byte_stream_tokenizer_top.sv]
// Self-checking testbench for byte_stream_tokenizer_top with an in-bench token predictor.
`timescale 1ns / 1ps

module tb_byte_stream_tokenizer_top;

  localparam int POS_W = 16;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam logic [23:0] KEYWORD_TEXT = "var";

  // One source byte or end marker as offered on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       closes_src;
  } src_item_t;

  // One token as seen on the output channel.
  typedef struct packed {
    logic [3:0]       kind;
    logic [POS_W-1:0] first_ofs;
    logic [POS_W-1:0] past_ofs;
    logic [POS_W-1:0] line_no;
    logic [POS_W-1:0] col_no;
    logic             last_of_item;
  } token_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       ch = 8'h00;
  logic             ch_present = 1'b0;
  logic             end_of_source = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       tok_kind;
  logic [POS_W-1:0] start_offset;
  logic [POS_W-1:0] end_offset;
  logic [POS_W-1:0] line_number;
  logic [POS_W-1:0] column_number;
  logic             run_last;
  logic             cfg_write = 1'b0;
  logic             cfg_index = bst_pkg::REG_FIRST_LINE;
  logic [bst_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  byte_stream_tokenizer_top #(.POSITION_BITS(POS_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .ch(ch), .ch_present(ch_present), .end_of_source(end_of_source),
    .out_valid(out_valid), .out_stall(out_stall),
    .tok_kind(tok_kind), .start_offset(start_offset), .end_offset(end_offset),
    .line_number(line_number), .column_number(column_number), .run_last(run_last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Stimulus and expectation stores.
  src_item_t pending_items[$];
  token_t    expected_tokens[$];
  token_t    item_tokens[$];
  src_item_t next_item;
  token_t    want;

  int queued_items   = 0;
  int accepted_items = 0;
  int tokens_checked = 0;
  int sources_closed = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  bit in_idling      = 1'b1;
  bit out_idling     = 1'b1;

  logic [7:0] punct_bytes [7] = '{bst_pkg::CH_COMMA, bst_pkg::CH_DOT, bst_pkg::CH_PLUS,
                                  bst_pkg::CH_MINUS, bst_pkg::CH_STAR, bst_pkg::CH_SLASH,
                                  bst_pkg::CH_EQ};

  // Predictor state: scanner, current position and register shadows.
  logic [1:0]       scan_state;
  logic [POS_W-1:0] span_ofs, span_line, span_col;
  logic [POS_W-1:0] pos_ofs, pos_line, pos_col;
  logic [2:0]       word_len;
  logic             word_is_var;
  logic [POS_W-1:0] line_base = 16'd1;
  logic [POS_W-1:0] col_base = '0;

  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic letter_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic token_t make_token(input logic [3:0] kind, input logic [POS_W-1:0] s,
                                        input logic [POS_W-1:0] e, input logic [POS_W-1:0] ln,
                                        input logic [POS_W-1:0] col);
    token_t t;
    t.kind = kind;
    t.first_ofs = s;
    t.past_ofs = e;
    t.line_no = ln;
    t.col_no = col;
    t.last_of_item = 1'b0;
    return t;
  endfunction

  function automatic void restart_source();
    scan_state = bst_pkg::MODE_IDLE;
    span_ofs = '0;
    span_line = '0;
    span_col = '0;
    pos_ofs = '0;
    pos_line = line_base;
    pos_col = col_base;
    word_len = '0;
    word_is_var = 1'b1;
  endfunction

  function automatic void advance();
    pos_ofs = bump(pos_ofs);
    pos_col = bump(pos_col);
  endfunction

  function automatic void mark_span();
    span_ofs = pos_ofs;
    span_line = pos_line;
    span_col = pos_col;
  endfunction

  // Emits a pending number or identifier, if any.
  function automatic void close_word();
    logic [3:0] kind;
    if (scan_state == bst_pkg::MODE_NUMBER) begin
      kind = bst_pkg::K_NUMBER;
    end else if (scan_state == bst_pkg::MODE_IDENT) begin
      kind = (word_is_var && word_len == bst_pkg::IDENT_LEN_KW) ? bst_pkg::K_VAR
                                                                : bst_pkg::K_IDENT;
    end else begin
      return;
    end
    item_tokens.push_back(make_token(kind, span_ofs, pos_ofs, span_line, span_col));
    scan_state = bst_pkg::MODE_IDLE;
  endfunction

  // Tracks whether the identifier so far still spells the keyword.
  function automatic void word_take(input logic [7:0] b);
    if (word_len < bst_pkg::IDENT_LEN_KW) begin
      if (b != KEYWORD_TEXT[23 - 8 * word_len -: 8]) word_is_var = 1'b0;
    end else begin
      word_is_var = 1'b0;
    end
    if (word_len < bst_pkg::IDENT_LEN_MAX) word_len = word_len + 1'b1;
  endfunction

  // Works out the tokens that one accepted item causes and queues them.
  function automatic void predict_tokens(input logic [7:0] b, input logic present,
                                         input logic closes_src);
    logic       taken;
    logic       single;
    logic [3:0] kind;
    token_t     t;
    item_tokens.delete();
    taken = 1'b0;
    if (present) begin
      if (scan_state == bst_pkg::MODE_NUMBER) begin
        if (digit_byte(b)) begin
          advance();
          taken = 1'b1;
        end else begin
          close_word();
        end
      end else if (scan_state == bst_pkg::MODE_IDENT) begin
        if (letter_byte(b) || b == bst_pkg::CH_UNDER) begin
          word_take(b);
          advance();
          taken = 1'b1;
        end else begin
          close_word();
        end
      end
      if (!taken) begin
        single = 1'b1;
        kind = bst_pkg::K_UNKNOWN;
        case (b)
          bst_pkg::CH_SPACE, bst_pkg::CH_TAB, bst_pkg::CH_CR: begin
            single = 1'b0;
            advance();
          end
          bst_pkg::CH_LF: begin
            single = 1'b0;
            item_tokens.push_back(make_token(bst_pkg::K_NEWLINE, pos_ofs, bump(pos_ofs),
                                             pos_line, pos_col));
            pos_ofs = bump(pos_ofs);
            pos_line = bump(pos_line);
            pos_col = col_base;
          end
          bst_pkg::CH_COMMA: kind = bst_pkg::K_COMMA;
          bst_pkg::CH_DOT:   kind = bst_pkg::K_DOT;
          bst_pkg::CH_PLUS:  kind = bst_pkg::K_PLUS;
          bst_pkg::CH_MINUS: kind = bst_pkg::K_MINUS;
          bst_pkg::CH_STAR:  kind = bst_pkg::K_STAR;
          bst_pkg::CH_SLASH: kind = bst_pkg::K_SLASH;
          bst_pkg::CH_EQ:    kind = bst_pkg::K_EQ;
          default: begin
            if (digit_byte(b)) begin
              single = 1'b0;
              mark_span();
              scan_state = bst_pkg::MODE_NUMBER;
              advance();
            end else if (letter_byte(b)) begin
              single = 1'b0;
              mark_span();
              scan_state = bst_pkg::MODE_IDENT;
              word_len = '0;
              word_is_var = 1'b1;
              word_take(b);
              advance();
            end
          end
        endcase
        if (single) begin
          item_tokens.push_back(make_token(kind, pos_ofs, bump(pos_ofs), pos_line, pos_col));
          advance();
        end
      end
    end
    if (closes_src) begin
      close_word();
      item_tokens.push_back(make_token(bst_pkg::K_END, pos_ofs, pos_ofs, pos_line, pos_col));
      restart_source();
      sources_closed++;
    end
    foreach (item_tokens[i]) begin
      t = item_tokens[i];
      t.last_of_item = (i == item_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  // A register write reloads the position only before the first byte of a source.
  function automatic void apply_reg(input logic idx, input logic [POS_W-1:0] value);
    if (idx == bst_pkg::REG_FIRST_LINE) line_base = value;
    else col_base = value;
    if (pos_ofs == '0) begin
      pos_line = line_base;
      pos_col = col_base;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t, token %0d: %s", $realtime, tokens_checked, what);
    mismatches++;
  endtask

  // Input driver: offers queued items, with a random wait after each transfer while in_idling is set.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tokens(ch, ch_present, end_of_source);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          ch <= next_item.data;
          ch_present <= next_item.present;
          end_of_source <= next_item.closes_src;
          in_valid <= 1'b1;
          gap_left = in_idling ? $urandom_range(0, 16) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each token transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                    tok_kind, start_offset));
        end else begin
          want = expected_tokens.pop_front();
          if (tok_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", tok_kind, want.kind));
          if (start_offset !== want.first_ofs)
            report_mismatch($sformatf("start_offset %0d, expected %0d",
                                      start_offset, want.first_ofs));
          if (end_offset !== want.past_ofs)
            report_mismatch($sformatf("end_offset %0d, expected %0d",
                                      end_offset, want.past_ofs));
          if (line_number !== want.line_no)
            report_mismatch($sformatf("line_number %0d, expected %0d",
                                      line_number, want.line_no));
          if (column_number !== want.col_no)
            report_mismatch($sformatf("column_number %0d, expected %0d",
                                      column_number, want.col_no));
          if (run_last !== want.last_of_item)
            report_mismatch($sformatf("run_last %0b, expected %0b",
                                      run_last, want.last_of_item));
        end
        tokens_checked++;
        stall_left = out_idling ? $urandom_range(0, 16) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic [7:0] data, input logic present, input logic closes_src);
    src_item_t it;
    it.data = data;
    it.present = present;
    it.closes_src = closes_src;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b1, 1'b0);
  endtask

  task automatic write_reg(input logic idx, input logic [POS_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, value);
    reg_writes++;
  endtask

  // Waits until every item is taken and every token has come out, then lets the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_items != queued_items || expected_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [POS_W-1:0] rand_setting();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_TOP;
      2:       return POS_W'($urandom_range(0, 20));
      default: return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly well-formed token sequences with random content, plus noise and end markers.
  task automatic add_random_phase(input int target);
    int base;
    int empties;
    int pick;
    base = queued_items;
    empties = 0;
    while (queued_items - base - empties < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        add_text("var");
        if ($urandom_range(0, 2) == 0) add_item(rand_letter(), 1'b1, 1'b0);
      end else if (pick < 30) begin
        add_item(rand_letter(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 6))
          add_item(($urandom_range(0, 4) == 0) ? bst_pkg::CH_UNDER : rand_letter(),
                   1'b1, 1'b0);
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 5)) add_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
      end else if (pick < 60) begin
        add_item(punct_bytes[$urandom_range(0, 6)], 1'b1, 1'b0);
      end else if (pick < 72) begin
        case ($urandom_range(0, 2))
          0:       add_item(bst_pkg::CH_SPACE, 1'b1, 1'b0);
          1:       add_item(bst_pkg::CH_TAB, 1'b1, 1'b0);
          default: add_item(bst_pkg::CH_CR, 1'b1, 1'b0);
        endcase
      end else if (pick < 80) begin
        add_item(bst_pkg::CH_LF, 1'b1, 1'b0);
      end else if (pick < 88) begin
        add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else if (pick < 91) begin
        add_item(bst_pkg::CH_UNDER, 1'b1, 1'b0);
      end else if (pick < 94) begin
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        empties++;
      end else if (pick < 97) begin
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
    end
  endtask

  // Main sequence: reset, directed sources, a gapless source, then random phases.
  initial begin
    restart_source();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every kind of token, keyword, leading underscore, extreme bytes, empty item,
    // a byte together with the end, and a bare end marker.
    add_text("var x_y,12.+-*/=\n");
    add_item(bst_pkg::CH_UNDER, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item("7", 1'b1, 1'b1);
    add_item(8'hFF, 1'b0, 1'b1);
    wait_idle();

    // Top line and column settings saturate on the first newline and byte.
    write_reg(bst_pkg::REG_FIRST_LINE, POS_TOP);
    write_reg(bst_pkg::REG_FIRST_COLUMN, POS_TOP);
    add_text("a\nb");
    add_item(bst_pkg::CH_SPACE, 1'b1, 1'b1);
    wait_idle();

    // A write in the middle of a source applies from the next source on.
    write_reg(bst_pkg::REG_FIRST_LINE, '0);
    write_reg(bst_pkg::REG_FIRST_COLUMN, '0);
    add_text("ab 1");
    wait_idle();
    write_reg(bst_pkg::REG_FIRST_LINE, 16'd7);
    add_text("\nq");
    add_item(8'h00, 1'b0, 1'b1);
    add_text("z");
    add_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // A source without gaps whose column runs into saturation inside a line.
    write_reg(bst_pkg::REG_FIRST_COLUMN, POS_TOP - 16'd3);
    in_idling = 1'b0;
    out_idling = 1'b0;
    add_text("abcdefg 12\n,x");
    add_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // Random phases, each with its own register settings and idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(bst_pkg::REG_FIRST_LINE, rand_setting());
      write_reg(bst_pkg::REG_FIRST_COLUMN, rand_setting());
      in_idling = ($urandom_range(0, 3) != 0);
      out_idling = ($urandom_range(0, 3) != 0);
      add_random_phase(50);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d source items, %0d tokens checked, %0d sources closed.",
             accepted_items, tokens_checked, sources_closed);
    $display("Registers were written %0d times, extremes and mid-source writes included.",
             reg_writes);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb_byte_stream_tokenizer_top passed");
    end else begin
      $display("tb_byte_stream_tokenizer_top failed");
    end
    $finish;
  end

  // Watchdog for a stuck handshake or a lost token.
  initial begin
    #2_000_000;
    $display("Timeout with %0d tokens still expected.", expected_tokens.size());
    $display("tb_byte_stream_tokenizer_top failed");
    $finish;
  end

endmodule
